// File: src/pvps_pkg.sv
// Shared types, constants and sample format helpers for the PCM volume and pan scaler.
package pvps_pkg;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S24 = 2'd2,
    FMT_S32 = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_STEREO = 2'd1,
    REG_VOLUME = 2'd2,
    REG_PAN    = 2'd3
  } reg_e;

  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned MAG_W      = 40;
  localparam logic [MAG_W-1:0] ROUND_HALF = MAG_W'(127);
  localparam logic [9:0] DIV_CONST   = 10'd255;

  function automatic logic signed [31:0] sample_extend(fmt_e fmt, logic [31:0] raw);
    logic signed [31:0] s;
    case (fmt)
      FMT_U8:  s = {{25{~raw[7]}}, raw[6:0]};
      FMT_S16: s = {{16{raw[15]}}, raw[15:0]};
      FMT_S24: s = {{8{raw[23]}}, raw[23:0]};
      FMT_S32: s = raw;
      default: s = raw;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sample_pack(fmt_e fmt, logic [31:0] r);
    logic [31:0] p;
    case (fmt)
      FMT_U8:  p = {24'd0, ~r[7], r[6:0]};
      FMT_S16: p = {16'd0, r[15:0]};
      FMT_S24: p = {8'd0, r[23:0]};
      FMT_S32: p = r;
      default: p = r;
    endcase
    return p;
  endfunction

endpackage

// File: src/pcm_volume_pan_scaler.sv
// Top level of the PCM volume and pan scaler: register port, flow control and two lanes.
// Each item holds two samples that run through two identical five-stage lanes, so one item
// is taken every clock cycle unless the input is stalled, and each stage registers it in turn;
// stall on the output backs up the pipeline, and the input stalls only once every stage is full.
module pcm_volume_pan_scaler import pvps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] sample_first_i,
  input  logic [31:0] sample_second_i,
  input  logic        is_last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] scaled_first_o,
  output logic [31:0] scaled_second_o,
  output logic        end_of_buffer_o
);

  fmt_e                  fmt_q;
  logic                  stereo_q;
  logic [7:0]            volume_q;
  logic [8:0]            pan_q;
  reg_e                  reg_idx;
  logic                  wr_en;
  logic [7:0]            left_gain, right_gain;
  logic [NUM_STAGES-1:0] vld_q, vld_d, last_q, load;

  assign reg_idx = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_S16;
      stereo_q <= 1'b1;
      volume_q <= 8'd255;
      pan_q    <= 9'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FORMAT: fmt_q    <= fmt_e'(pwdata[1:0]);
        REG_STEREO: stereo_q <= pwdata[0];
        REG_VOLUME: volume_q <= pwdata[7:0];
        REG_PAN:    pan_q    <= pwdata[8:0];
        default:    fmt_q    <= fmt_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FORMAT: prdata = {30'd0, fmt_q};
      REG_STEREO: prdata = {31'd0, stereo_q};
      REG_VOLUME: prdata = {24'd0, volume_q};
      REG_PAN:    prdata = {23'd0, pan_q};
      default:    prdata = 32'd0;
    endcase
  end

  pvps_gain u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stereo_i     (stereo_q),
    .volume_i     (volume_q),
    .pan_i        (pan_q),
    .left_gain_o  (left_gain),
    .right_gain_o (right_gain)
  );

  always_comb begin
    load[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    vld_d[0] = valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (load[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      last_q[0] <= is_last_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  pvps_lane u_lane_first (
    .clk_i    (clk_i),
    .fmt_i    (fmt_q),
    .gain_i   (left_gain),
    .load_i   (load),
    .sample_i (sample_first_i),
    .scaled_o (scaled_first_o)
  );

  pvps_lane u_lane_second (
    .clk_i    (clk_i),
    .fmt_i    (fmt_q),
    .gain_i   (right_gain),
    .load_i   (load),
    .sample_i (sample_second_i),
    .scaled_o (scaled_second_o)
  );

  assign stall_o         = !load[0];
  assign valid_o         = vld_q[NUM_STAGES-1];
  assign end_of_buffer_o = last_q[NUM_STAGES-1];

endmodule

// File: src/pvps_gain.sv
// Per-channel gain derived from volume, pan and stereo mode, registered.
module pvps_gain import pvps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             stereo_i,
  input  logic [7:0]       volume_i,
  input  logic [8:0]       pan_i,
  output logic [7:0]       left_gain_o,
  output logic [7:0]       right_gain_o
);

  logic        pan_neg;
  logic [7:0]  pan_abs;
  logic [7:0]  keep;
  logic [15:0] atten;
  logic [7:0]  atten_gain;
  logic [7:0]  left_gain_d, right_gain_d;
  logic [7:0]  left_gain_q, right_gain_q;

  always_comb begin
    pan_neg = pan_i[8];
    if (pan_neg) begin
      pan_abs = (pan_i < 9'h180) ? 8'd128 : 8'(9'd0 - pan_i);
    end else begin
      pan_abs = (pan_i > 9'd128) ? 8'd128 : pan_i[7:0];
    end
    keep       = 8'd128 - pan_abs;
    atten      = volume_i * keep + 16'd64;
    atten_gain = atten[14:7];
    left_gain_d  = volume_i;
    right_gain_d = volume_i;
    if (stereo_i && pan_abs != 8'd0) begin
      if (pan_neg) begin
        right_gain_d = atten_gain;
      end else begin
        left_gain_d = atten_gain;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_gain_q  <= 8'd255;
      right_gain_q <= 8'd255;
    end else begin
      left_gain_q  <= left_gain_d;
      right_gain_q <= right_gain_d;
    end
  end

  assign left_gain_o  = left_gain_q;
  assign right_gain_o = right_gain_q;

endmodule

// File: src/pvps_lane.sv
// One sample lane: sign extension, gain multiply, rounded divide by 255 and repacking.
module pvps_lane import pvps_pkg::*; (
  input  logic                  clk_i,
  input  fmt_e                  fmt_i,
  input  logic [7:0]            gain_i,
  input  logic [NUM_STAGES-1:0] load_i,
  input  logic [31:0]           sample_i,
  output logic [31:0]           scaled_o
);

  logic signed [31:0]       samp_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic                     neg2_q, neg3_q;
  logic [MAG_W-1:0]         mag_d, mag_q;
  logic [MAG_W-1:0]         est_sum;
  logic [31:0]              quot_q;
  logic [9:0]               low_q;
  logic [9:0]               rem;
  logic                     carry;
  logic [31:0]              res_d, res_q;

  always_comb begin
    prod_d = samp_q * $signed({1'b0, gain_i});
    mag_d  = (prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q)) + ROUND_HALF;
    est_sum = mag_q + (mag_q >> 8) + (mag_q >> 16) + (mag_q >> 24) + (mag_q >> 32);
    rem   = low_q - {quot_q[1:0], 8'd0} + quot_q[9:0];
    carry = (rem >= DIV_CONST);
    if (neg3_q) begin
      res_d = ~quot_q + {31'd0, ~carry};
    end else begin
      res_d = quot_q + {31'd0, carry};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      samp_q <= sample_extend(fmt_i, sample_i);
    end
    if (load_i[1]) begin
      prod_q <= prod_d;
    end
    if (load_i[2]) begin
      neg2_q <= prod_q[PROD_W-1];
      mag_q  <= mag_d;
    end
    if (load_i[3]) begin
      neg3_q <= neg2_q;
      quot_q <= est_sum[39:8];
      low_q  <= mag_q[9:0];
    end
    if (load_i[4]) begin
      res_q <= sample_pack(fmt_i, res_d);
    end
  end

  assign scaled_o = res_q;

endmodule

// File: src/pvps_checker.sv
// Port-level checker for the PCM volume and pan scaler, bound to the top level.
module pvps_checker import pvps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] scaled_first_o,
  input logic [31:0] scaled_second_o
);

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;
  fmt_e       fmt_q;

  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
      fmt_q      <= FMT_S16;
    end else begin
      inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
      if (psel && penable && pwrite && reg_e'(paddr[3:2]) == REG_FORMAT) begin
        fmt_q <= fmt_e'(pwdata[1:0]);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("Stalled result item dropped.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> inflight_q != 3'd0)
    else $error("Result item without an accepted input item.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(NUM_STAGES))
    else $error("More items in flight than pipeline stages.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q < 3'(NUM_STAGES) |-> !stall_o)
    else $error("Input stalled while the pipeline has room.");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && fmt_q == FMT_S16 |->
      scaled_first_o[31:16] == 16'd0 && scaled_second_o[31:16] == 16'd0)
    else $error("Bits above the 16-bit sample are not zero.");

endmodule

bind pcm_volume_pan_scaler pvps_checker u_pvps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .valid_i         (valid_i),
  .stall_o         (stall_o),
  .valid_o         (valid_o),
  .stall_i         (stall_i),
  .scaled_first_o  (scaled_first_o),
  .scaled_second_o (scaled_second_o)
);

// File: tb/pcm_scale_checker.sv
`timescale 1ns / 100ps
// Checker for the PCM volume and pan scaler: follows register writes, predicts each frame and compares.
module pcm_scale_checker import pvps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [31:0] sample_first_i,
  input  logic [31:0] sample_second_i,
  input  logic        is_last_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [31:0] scaled_first_o,
  input  logic [31:0] scaled_second_o,
  input  logic        end_of_buffer_o,
  output int          mismatches,
  output int          frames_outstanding,
  output int          frames_checked
);

  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
    logic        last;
  } frame_t;

  frame_t            scaled_q[$];
  fmt_e              cur_fmt;
  logic              cur_stereo;
  logic [7:0]        cur_volume;
  logic signed [8:0] cur_pan;

  function automatic logic [7:0] side_gain(logic [7:0] vol, int unsigned share);
    return 8'((vol * share + 64) / 128);
  endfunction

  function automatic logic [31:0] scaled_sample(fmt_e fmt, logic [31:0] raw, logic [7:0] gain);
    logic signed [7:0]  s8;
    logic signed [15:0] s16;
    logic signed [23:0] s24;
    logic signed [31:0] s32;
    longint             s;
    longint             prod;
    longint             q;
    logic [31:0]        r;
    s8 = raw[7:0] ^ 8'h80;
    s16 = raw[15:0];
    s24 = raw[23:0];
    s32 = raw;
    case (fmt)
      FMT_U8:  s = s8;
      FMT_S16: s = s16;
      FMT_S24: s = s24;
      default: s = s32;
    endcase
    prod = s * longint'(gain);
    q = ((prod < 0) ? -prod : prod);
    q = (q + 127) / 255;
    if (prod < 0) q = -q;
    r = q[31:0];
    case (fmt)
      FMT_U8:  return {24'd0, r[7:0] ^ 8'h80};
      FMT_S16: return {16'd0, r[15:0]};
      FMT_S24: return {8'd0, r[23:0]};
      default: return r;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %h, wanted %h", $time, what, got, wanted);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t     want;
    logic [7:0] left_gain;
    logic [7:0] right_gain;
    int         p;
    if (!rst_ni) begin
      cur_fmt = FMT_S16;
      cur_stereo = 1'b1;
      cur_volume = 8'd255;
      cur_pan = 9'sd0;
      scaled_q.delete();
      mismatches = 0;
      frames_outstanding = 0;
      frames_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[3:2]))
          REG_FORMAT: cur_fmt = fmt_e'(pwdata[1:0]);
          REG_STEREO: cur_stereo = pwdata[0];
          REG_VOLUME: cur_volume = pwdata[7:0];
          REG_PAN:    cur_pan = pwdata[8:0];
          default: ;
        endcase
      end
      if (valid_i && !stall_o) begin
        left_gain = cur_volume;
        right_gain = cur_volume;
        p = cur_pan;
        if (p < -128) p = -128;
        if (p > 128) p = 128;
        if (cur_stereo && p < 0) begin
          right_gain = side_gain(cur_volume, 128 + p);
        end else if (cur_stereo && p > 0) begin
          left_gain = side_gain(cur_volume, 128 - p);
        end
        want.first = scaled_sample(cur_fmt, sample_first_i, left_gain);
        want.second = scaled_sample(cur_fmt, sample_second_i, right_gain);
        want.last = is_last_i;
        scaled_q.push_back(want);
      end
      if (valid_o && !stall_i) begin
        frames_checked++;
        if (scaled_q.size() == 0) begin
          report_mismatch("result with no frame pending", scaled_first_o, 32'd0);
        end else begin
          want = scaled_q.pop_front();
          if (scaled_first_o !== want.first) begin
            report_mismatch("scaled_first", scaled_first_o, want.first);
          end
          if (scaled_second_o !== want.second) begin
            report_mismatch("scaled_second", scaled_second_o, want.second);
          end
          if (end_of_buffer_o !== want.last) begin
            report_mismatch("end_of_buffer", 32'(end_of_buffer_o), 32'(want.last));
          end
        end
      end
      frames_outstanding = scaled_q.size();
    end
  end

endmodule

// File: tb/tb_pcm_volume_pan_scaler.sv
`timescale 1ns / 100ps
// Testbench top for the PCM volume and pan scaler: clock, reset, register setup, frames and verdict.
module tb_pcm_volume_pan_scaler;
  import pvps_pkg::*;

  localparam int ITEM_TARGET    = 2000;
  localparam int DIRECTED_ITEMS = 21;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = NUM_STAGES + 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] sample_first_i = '0;
  logic [31:0] sample_second_i = '0;
  logic        is_last_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] scaled_first_o;
  logic [31:0] scaled_second_o;
  logic        end_of_buffer_o;

  int          mismatches;
  int          frames_outstanding;
  int          frames_checked;
  int          frames_sent = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;
  int          out_wait = 0;
  int          stall_draw;
  logic        quiet = 1'b0;
  logic [3:0]  formats_seen = '0;
  logic [1:0]  modes_seen = '0;

  always #5 clk_i = ~clk_i;

  pcm_volume_pan_scaler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .is_last_i       (is_last_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .scaled_first_o  (scaled_first_o),
    .scaled_second_o (scaled_second_o),
    .end_of_buffer_o (end_of_buffer_o)
  );

  pcm_scale_checker scale_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .sample_first_i     (sample_first_i),
    .sample_second_i    (sample_second_i),
    .is_last_i          (is_last_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .scaled_first_o     (scaled_first_o),
    .scaled_second_o    (scaled_second_o),
    .end_of_buffer_o    (end_of_buffer_o),
    .mismatches         (mismatches),
    .frames_outstanding (frames_outstanding),
    .frames_checked     (frames_checked)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      out_wait <= 0;
    end else if (valid_o && !stall_i) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 8);
      out_wait <= stall_draw;
      stall_i <= (stall_draw != 0);
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait <= 0;
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    valid_i <= 1'b0;
    @(negedge clk_i);
    while (frames_outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input fmt_e fmt, input logic stereo, input logic [7:0] vol,
                            input logic [8:0] pan);
    wait_idle();
    reg_write(REG_FORMAT, 32'(fmt));
    reg_write(REG_STEREO, 32'(stereo));
    reg_write(REG_VOLUME, 32'(vol));
    reg_write(REG_PAN, 32'(pan));
    formats_seen[fmt] = 1'b1;
    modes_seen[stereo] = 1'b1;
    settings_used++;
  endtask

  task automatic send_frame(input logic [31:0] first, input logic [31:0] second,
                            input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    sample_first_i <= first;
    sample_second_i <= second;
    is_last_i <= last;
    @(negedge clk_i);
    while (stall_o) @(negedge clk_i);
    @(posedge clk_i);
    frames_sent++;
  endtask

  task automatic send_extremes();
    send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_frame(32'h0080_8080, 32'hFF7F_7F7F, 1'b1);
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      0: r[23:0] = 24'h80_0000;
      1: r[23:0] = 24'h7F_FFFF;
      2: r[15:0] = 16'h8000;
      3: r[15:0] = 16'h7FFF;
      4: r = 32'h8000_0000;
      5: r = 32'h7FFF_FFFF;
      6: r[7:0] = 8'h80;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rand_volume();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] rand_pan();
    int p;
    case ($urandom_range(0, 9))
      0: p = -128;
      1: p = 128;
      2: p = 0;
      3: p = $urandom_range(0, 511);
      default: p = int'($urandom_range(0, 256)) - 128;
    endcase
    return 9'(p);
  endfunction

  initial begin
    int burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_extremes();
    set_config(FMT_U8, 1'b1, 8'd255, 9'h180);
    send_extremes();
    set_config(FMT_S24, 1'b1, 8'd0, 9'h080);
    send_extremes();
    set_config(FMT_S32, 1'b1, 8'd128, 9'h1FF);
    send_extremes();
    set_config(FMT_S32, 1'b1, 8'd255, 9'h0FF);
    send_extremes();
    set_config(FMT_U8, 1'b0, 8'd1, 9'h100);
    send_extremes();
    set_config(FMT_S16, 1'b1, 8'd200, 9'h100);
    send_extremes();

    while (frames_sent < ITEM_TARGET + DIRECTED_ITEMS) begin
      set_config(fmt_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_volume(),
                 rand_pan());
      quiet = ($urandom_range(0, 3) == 0);
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : $urandom_range(20, 150);
      repeat (burst) send_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
    end
    quiet = 1'b0;

    wait_idle();
    repeat (NUM_STAGES * 4) @(posedge clk_i);
    $display("Sent %0d frames under %0d register settings and checked %0d results.",
             frames_sent, settings_used, frames_checked);
    $display("Sample formats used (mask) %b, mono/stereo used (mask) %b.",
             formats_seen, modes_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: pcm_volume_pan_scaler.f
src/pvps_pkg.sv
src/pvps_gain.sv
src/pvps_lane.sv
src/pcm_volume_pan_scaler.sv
src/pvps_checker.sv
tb/pcm_scale_checker.sv
tb/tb_pcm_volume_pan_scaler.sv
